### src/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types and constants for the global longitude decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gld_pkg;

    localparam int CODE_IN_W  = 17;   // width of each encoded longitude field
    localparam int ZONE_W     = 6;    // width of zone count and zone index
    localparam int LON_W      = 33;   // width of the longitude field
    localparam int NL_MIN     = 2;
    localparam int NL_MAX     = 59;
    localparam int DEG_FULL   = 360;
    localparam int DEG_FULL_W = 9;    // bits to hold DEG_FULL
    localparam int DIV_DIGITS = 4;    // quotient bits resolved per divider stage

    // Side information that rides along with each beat through the pipe
    typedef struct packed {
        logic              bad;
        logic [ZONE_W-1:0] nl;
        logic [ZONE_W-1:0] zone;
    } gld_side_t;

endpackage

`default_nettype wire

### src/gld_zone.sv
// ----------------------------------------------------------------------------
// gld_zone
// Front pipeline: zone number m, zone index j and the scaled dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module gld_zone #(
    parameter int CODE_BITS     = 17,
    parameter int FRACTION_BITS = 24,
    parameter int NW            = FRACTION_BITS + 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [gld_pkg::CODE_IN_W-1:0] even_lon_code,
    input  wire logic [gld_pkg::CODE_IN_W-1:0] odd_lon_code,
    input  wire logic [gld_pkg::ZONE_W-1:0]    zone_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [NW-1:0]                      out_num,
    output gld_pkg::gld_side_t                 out_side
);
    import gld_pkg::*;

    localparam int B    = CODE_BITS;
    localparam int XW   = (B > CODE_IN_W) ? B : CODE_IN_W;
    localparam int PW   = B + ZONE_W;          // product width
    localparam int SW   = B + 8;               // signed sum width
    localparam int MW   = 8;                   // zone number width, signed
    localparam int VW   = B + ZONE_W;          // j*2^B + xz0
    localparam int AW   = VW + DEG_FULL_W;     // times 360
    localparam int SH_L = (FRACTION_BITS + 1 >= B) ? FRACTION_BITS + 1 - B : 0;
    localparam int SH_R = (FRACTION_BITS + 1 >= B) ? 0 : B - FRACTION_BITS - 1;
    localparam int TW   = AW + SH_L;

    // stage A: validate, products
    logic              a_valid_reg;
    logic [PW-1:0]     a_p0_reg, a_p1_reg;
    logic [B-1:0]      a_xz0_reg;
    logic [ZONE_W-1:0] a_nl_reg;
    logic              a_bad_reg;
    // stage B: zone number
    logic              b_valid_reg;
    logic signed [MW-1:0] b_m_reg;
    logic [B-1:0]      b_xz0_reg;
    logic [ZONE_W-1:0] b_nl_reg;
    logic              b_bad_reg;
    // stage C: zone index
    logic              c_valid_reg;
    logic [VW-1:0]     c_v_reg;
    gld_side_t         c_side_reg;
    // stage D: dividend
    logic              d_valid_reg;
    logic [NW-1:0]     d_num_reg;
    gld_side_t         d_side_reg;

    logic a_ready, b_ready, c_ready, d_ready;

    logic [XW-1:0]     xz0_ext, xz1_ext;
    logic [B-1:0]      xz0, xz1;
    logic [PW-1:0]     p0_next, p1_next;
    logic              bad_next;
    logic signed [SW-1:0] sum;
    logic [MW-1:0]     m_plus_nl;
    logic [ZONE_W-1:0] j_next;
    logic [AW-1:0]     a_prod;
    logic [TW-1:0]     a_shift;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // only the low CODE_BITS bits of each code take part
    assign xz0_ext  = XW'(even_lon_code);
    assign xz1_ext  = XW'(odd_lon_code);
    assign xz0      = xz0_ext[B-1:0];
    assign xz1      = xz1_ext[B-1:0];
    assign bad_next = (zone_count < ZONE_W'(NL_MIN)) || (zone_count > ZONE_W'(NL_MAX));
    assign p0_next  = PW'(zone_count - ZONE_W'(1)) * PW'(xz0);
    assign p1_next  = PW'(zone_count) * PW'(xz1);

    // floor division by 2^B is the arithmetic shift of the two's complement sum
    assign sum = $signed(SW'(a_p0_reg)) - $signed(SW'(a_p1_reg))
               + $signed(SW'(1) << (B - 1));

    // m lies in [-nl, nl-1], so one correction gives the floor modulo
    assign m_plus_nl = b_m_reg + $signed(MW'(b_nl_reg));
    assign j_next    = b_m_reg[MW-1] ? m_plus_nl[ZONE_W-1:0] : b_m_reg[ZONE_W-1:0];

    assign a_prod  = AW'(c_v_reg) * AW'(DEG_FULL);
    assign a_shift = TW'(a_prod) << SH_L;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_p0_reg  <= p0_next;
            a_p1_reg  <= p1_next;
            a_xz0_reg <= xz0;
            a_nl_reg  <= zone_count;
            a_bad_reg <= bad_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_m_reg   <= sum[SW-1:B];
            b_xz0_reg <= a_xz0_reg;
            b_nl_reg  <= a_nl_reg;
            b_bad_reg <= a_bad_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_v_reg         <= {j_next, b_xz0_reg};
            c_side_reg.bad  <= b_bad_reg;
            c_side_reg.nl   <= b_nl_reg;
            c_side_reg.zone <= j_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_num_reg  <= NW'(a_shift >> SH_R);
            d_side_reg <= c_side_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_num   = d_num_reg;
    assign out_side  = d_side_reg;

endmodule

`default_nettype wire

### src/gld_div_stage.sv
// ----------------------------------------------------------------------------
// gld_div_stage
// One stage of the restoring divider by the zone count, DIV_DIGITS bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gld_div_stage #(
    parameter int W = 40
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [W-1:0]               in_work,
    input  wire logic [gld_pkg::ZONE_W-1:0] in_rem,
    input  wire gld_pkg::gld_side_t         in_side,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [W-1:0]                    out_work,
    output logic [gld_pkg::ZONE_W-1:0]      out_rem,
    output gld_pkg::gld_side_t              out_side
);
    import gld_pkg::*;

    logic              valid_reg;
    logic [W-1:0]      work_reg;
    logic [ZONE_W-1:0] rem_reg;
    gld_side_t         side_reg;

    logic [W-1:0]      work_next;
    logic [ZONE_W-1:0] rem_next;

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_comb
    begin
        logic [ZONE_W:0] t;
        logic            ge;
        work_next = in_work;
        rem_next  = in_rem;
        for (int s = 0; s < DIV_DIGITS; s++)
        begin
            t         = {rem_next, work_next[W-1]};
            ge        = (t >= {1'b0, in_side.nl});
            rem_next  = ge ? ZONE_W'(t - {1'b0, in_side.nl}) : t[ZONE_W-1:0];
            work_next = {work_next[W-2:0], ge};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;
    assign out_rem   = rem_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

### src/gld_round.sv
// ----------------------------------------------------------------------------
// gld_round
// Output stage: round the doubled quotient, wrap a full circle, zero bad beats.
// ----------------------------------------------------------------------------
`default_nettype none

module gld_round #(
    parameter int FRACTION_BITS = 24,
    parameter int QW            = 40
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [QW-1:0]              in_quot,
    input  wire gld_pkg::gld_side_t         in_side,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [gld_pkg::LON_W-1:0]       longitude_q24,
    output logic [gld_pkg::ZONE_W-1:0]      zone_index,
    output logic                            bad_zone_count
);
    import gld_pkg::*;

    localparam int LW = FRACTION_BITS + DEG_FULL_W;
    // doubled quotient at or above this rounds to a full circle
    localparam logic [QW-1:0] WRAP_Q = (QW'(2 * DEG_FULL) << FRACTION_BITS) - QW'(1);

    logic              valid_reg;
    logic [LON_W-1:0]  lon_reg;
    logic [ZONE_W-1:0] zone_reg;
    logic              bad_reg;

    logic [QW:0]       inc;
    logic [LW-1:0]     q;
    logic              wrap;

    assign inc  = (QW + 1)'(in_quot) + (QW + 1)'(1);
    assign q    = inc[LW:1];
    assign wrap = (in_quot >= WRAP_Q);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            lon_reg  <= (in_side.bad || wrap) ? '0 : LON_W'(q);
            zone_reg <= in_side.bad ? '0 : in_side.zone;
            bad_reg  <= in_side.bad;
        end
    end

    assign out_valid      = valid_reg;
    assign longitude_q24  = lon_reg;
    assign zone_index     = zone_reg;
    assign bad_zone_count = bad_reg;

endmodule

`default_nettype wire

### src/global_longitude_decode_top.sv
// ----------------------------------------------------------------------------
// global_longitude_decode_top
// Global longitude decode of an even/odd pair of compact position codes.
//
//   Channel   Dir  Payload
//   s_axis    in   tdata: even_lon_code[16:0], odd_lon_code[33:17],
//                         zone_count[39:34]
//   m_axis    out  tdata: longitude_q24[32:0], zone_index[38:33], zero[39]
//                  tuser: bad_zone_count
//
// One beat per cycle is accepted and delivered in steady state, while
// m_axis_tready stays high. The pipe is four front stages, the divider by the
// zone count at four quotient bits per stage, and the output register.
// Reset clears only the valid bits; the pipe is empty after reset.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and input is still taken while a result waits at the output,
// until every stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module global_longitude_decode_top #(
    parameter int CODE_BITS     = 17,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // even_lon_code, odd_lon_code, zone_count
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // longitude_q24, zone_index, zero pad
    output logic             m_axis_tuser    // bad_zone_count
);
    import gld_pkg::*;

    localparam int NW   = FRACTION_BITS + 16;
    localparam int NWP  = ((NW + DIV_DIGITS - 1) / DIV_DIGITS) * DIV_DIGITS;
    localparam int NSTG = NWP / DIV_DIGITS;

    logic              z_valid, z_ready;
    logic [NW-1:0]     z_num;
    gld_side_t         z_side;

    logic              dv   [NSTG+1];
    logic              dr   [NSTG+1];
    logic [NWP-1:0]    dw   [NSTG+1];
    logic [ZONE_W-1:0] drem [NSTG+1];
    gld_side_t         dside[NSTG+1];

    logic [LON_W-1:0]  lon;
    logic [ZONE_W-1:0] zone;
    logic              bad;

    gld_zone #(
        .CODE_BITS    (CODE_BITS),
        .FRACTION_BITS(FRACTION_BITS),
        .NW           (NW)
    ) u_zone (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .even_lon_code(s_axis_tdata[16:0]),
        .odd_lon_code (s_axis_tdata[33:17]),
        .zone_count   (s_axis_tdata[39:34]),
        .out_valid    (z_valid),
        .out_ready    (z_ready),
        .out_num      (z_num),
        .out_side     (z_side)
    );

    assign dv[0]    = z_valid;
    assign z_ready  = dr[0];
    assign dw[0]    = NWP'(z_num);
    assign drem[0]  = '0;
    assign dside[0] = z_side;

    for (genvar i = 0; i < NSTG; i++)
    begin : g_div
        gld_div_stage #(
            .W(NWP)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (dv[i]),
            .in_ready (dr[i]),
            .in_work  (dw[i]),
            .in_rem   (drem[i]),
            .in_side  (dside[i]),
            .out_valid(dv[i+1]),
            .out_ready(dr[i+1]),
            .out_work (dw[i+1]),
            .out_rem  (drem[i+1]),
            .out_side (dside[i+1])
        );
    end

    gld_round #(
        .FRACTION_BITS(FRACTION_BITS),
        .QW           (NWP)
    ) u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (dv[NSTG]),
        .in_ready      (dr[NSTG]),
        .in_quot       (dw[NSTG]),
        .in_side       (dside[NSTG]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .longitude_q24 (lon),
        .zone_index    (zone),
        .bad_zone_count(bad)
    );

    assign m_axis_tdata = {1'b0, zone, lon};
    assign m_axis_tuser = bad;

endmodule

`default_nettype wire

### src/gld_checker.sv
// ----------------------------------------------------------------------------
// gld_checker
// Port-level checks on the global longitude decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gld_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    import gld_pkg::*;

    logic [7:0] inflight_reg;
    logic [7:0] inflight_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat)
        begin
            inflight_next = inflight_reg + 8'd1;
        end
        else if (out_beat && !in_beat)
        begin
            inflight_next = inflight_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a flagged zone count carries an all-zero payload
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 40'd0)
        else $error("bad zone count beat with nonzero payload");

    // zone index stays below the largest zone count
    a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[38:33] <= 6'(NL_MAX - 1))
        else $error("zone index out of range");

    // no result without an accepted input still owed
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 8'd0)
        else $error("result beat without a pending input beat");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind global_longitude_decode_top gld_checker u_gld_checker (.*);

`default_nettype wire
